// ===== src/mrs_pkg.sv =====
// mrs_pkg: shared types and codes for the modulation range shaper.
// No dependencies; imported by the top level.
package mrs_pkg;

  // polarity codes on the input word
  localparam logic [1:0] POL_NEG = 2'd0;
  localparam logic [1:0] POL_POS = 2'd1;
  localparam logic [1:0] POL_BIP = 2'd2;

  // how the base moves once polarity and source side are known
  typedef enum logic [1:0] {
    MOVE_UP,    // toward max, scaled by headroom above base
    MOVE_DOWN,  // toward min, scaled by distance below base
    MOVE_NEG    // distance above min scaled by gain
  } move_t;

endpackage

// ===== src/mrs_req_if.sv =====
// mrs_req_if: input channel of the modulation range shaper.
// Valid/ready handshake carrying one request word; no package dependency.
interface mrs_req_if #(
  parameter int VALUE_BITS    = 16,
  parameter int FRACTION_BITS = 16
);
  logic                     valid;
  logic                     ready;
  logic [VALUE_BITS-1:0]    base_value;
  logic [VALUE_BITS-1:0]    range_min;
  logic [VALUE_BITS-1:0]    range_max;
  logic [FRACTION_BITS:0]   source_level;
  logic [FRACTION_BITS:0]   depth;
  logic [1:0]               polarity;

  modport source (
    output valid, base_value, range_min, range_max, source_level, depth, polarity,
    input  ready
  );
  modport sink (
    input  valid, base_value, range_min, range_max, source_level, depth, polarity,
    output ready
  );
endinterface

// ===== src/mrs_rsp_if.sv =====
// mrs_rsp_if: output channel of the modulation range shaper.
// Valid/ready handshake carrying one result word; no package dependency.
interface mrs_rsp_if #(
  parameter int VALUE_BITS = 16
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] shaped_value;

  modport source (
    output valid, shaped_value,
    input  ready
  );
  modport sink (
    input  valid, shaped_value,
    output ready
  );
endinterface

// ===== src/modulation_range_shaper.sv =====
// modulation_range_shaper: five-stage pipeline shaping a value by a modulation
// source and depth inside a legal range. Uses mrs_pkg, mrs_req_if, mrs_rsp_if.
//
// Usage:
//   req (sink): base_value, range_min, range_max, source_level, depth and
//   polarity; a word is taken when req.valid and req.ready are both high.
//   rsp (source): shaped_value, one word out for every word taken, in order.
//   Source and depth are unsigned Q1.F (1 << FRACTION_BITS is 1.0).
// Pipeline: five register stages; the first loads on the accepting edge
//   (stages: range/term prep, depth*term multiply, round and gain select,
//   gain*distance multiply, accumulate/clamp into the output register).
// Throughput: one word per cycle while rsp is not stalled; the two multipliers
//   are each fully pipelined, so nothing recirculates.
// Stall: the whole pipe advances on one enable, high whenever the output
//   register is empty or being drained. While rsp is stalled with a word
//   held, req.ready is low and every stage holds its word.
// Reset: rst (synchronous, active high) clears all stage valid bits and holds
//   req.ready low; the data registers need no reset, so the block is ready the
//   cycle after reset.
module modulation_range_shaper
  import mrs_pkg::*;
#(
  parameter int VALUE_BITS    = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  mrs_req_if.sink    req,
  mrs_rsp_if.source  rsp
);

  localparam int V  = VALUE_BITS;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * F + 2;   // depth * term product
  localparam int W  = V + F + 1;   // accumulator

  localparam logic [F:0]    ONE    = (F + 1)'(1) << F;
  localparam logic [F+1:0]  ONE_X  = (F + 2)'(1) << F;
  localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);
  localparam logic [W-1:0]  HALF_W = W'(1) << (F - 1);

  // single pipeline enable: advance when output is free or draining
  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv && !rst;

  logic [4:1] vld;

  // ---------------------------------------------------------------
  // Stage 1: order range, clamp base, saturate source/depth, pick term
  // ---------------------------------------------------------------
  logic [V-1:0]   lo_c, hi_c, b_c;
  logic [F:0]     s_c, d_c, t_c;
  logic [F+1:0]   s2_c;
  move_t          mv_c;

  always_comb begin
    if (req.range_max < req.range_min) begin
      lo_c = req.range_max;
      hi_c = req.range_min;
    end else begin
      lo_c = req.range_min;
      hi_c = req.range_max;
    end
    if (req.base_value < lo_c) b_c = lo_c;
    else if (req.base_value > hi_c) b_c = hi_c;
    else b_c = req.base_value;

    s_c  = (req.source_level > ONE) ? ONE : req.source_level;
    d_c  = (req.depth > ONE) ? ONE : req.depth;
    s2_c = {s_c, 1'b0};

    unique case (req.polarity)
      POL_POS: begin
        mv_c = MOVE_UP;
        t_c  = s_c;
      end
      POL_BIP: begin
        // map source to -1..1; magnitude is the term, sign picks side
        if (s2_c >= ONE_X) begin
          mv_c = MOVE_UP;
          t_c  = (F + 1)'(s2_c - ONE_X);
        end else begin
          mv_c = MOVE_DOWN;
          t_c  = (F + 1)'(ONE_X - s2_c);
        end
      end
      default: begin  // negative, and code three
        mv_c = MOVE_NEG;
        t_c  = s_c;
      end
    endcase
  end

  logic [V-1:0] lo1, hi1, b1;
  logic [F:0]   d1, t1;
  move_t        mv1;

  always_ff @(posedge clk) begin
    if (adv) begin
      lo1 <= lo_c;
      hi1 <= hi_c;
      b1  <= b_c;
      d1  <= d_c;
      t1  <= t_c;
      mv1 <= mv_c;
    end
  end

  // ---------------------------------------------------------------
  // Stage 2: depth * term, distance the gain applies to
  // ---------------------------------------------------------------
  logic [PW-1:0] prod2;
  logic [V-1:0]  lo2, hi2, b2, dist2;
  logic [F:0]    d2;
  move_t         mv2;

  always_ff @(posedge clk) begin
    if (adv) begin
      prod2 <= PW'(d1) * PW'(t1);
      dist2 <= (mv1 == MOVE_UP) ? (hi1 - b1) : (b1 - lo1);
      lo2   <= lo1;
      hi2   <= hi1;
      b2    <= b1;
      d2    <= d1;
      mv2   <= mv1;
    end
  end

  // ---------------------------------------------------------------
  // Stage 3: round product to Q1.F, form negative-polarity gain
  // ---------------------------------------------------------------
  logic [PW-1:0] prod_rnd;
  logic [F:0]    k_c, g_c;

  always_comb begin
    prod_rnd = prod2 + HALF_P;
    k_c      = prod_rnd[F+F:F];          // never exceeds ONE
    g_c      = (ONE - d2) + k_c;         // 1 - d + d*s, within 0..ONE
  end

  logic [F:0]   m3;
  logic [V-1:0] lo3, hi3, b3, dist3;
  move_t        mv3;

  always_ff @(posedge clk) begin
    if (adv) begin
      m3    <= (mv2 == MOVE_NEG) ? g_c : k_c;
      dist3 <= dist2;
      lo3   <= lo2;
      hi3   <= hi2;
      b3    <= b2;
      mv3   <= mv2;
    end
  end

  // ---------------------------------------------------------------
  // Stage 4: gain * distance
  // ---------------------------------------------------------------
  logic [W-1:0] p4;
  logic [V-1:0] lo4, hi4, b4;
  move_t        mv4;

  always_ff @(posedge clk) begin
    if (adv) begin
      p4  <= W'(m3) * W'(dist3);
      lo4 <= lo3;
      hi4 <= hi3;
      b4  <= b3;
      mv4 <= mv3;
    end
  end

  // ---------------------------------------------------------------
  // Stage 5: accumulate onto the anchor, round half up, clamp
  // ---------------------------------------------------------------
  logic [W-1:0] base_sh, acc_c;
  logic [V:0]   r_raw;
  logic [V-1:0] r_c;

  always_comb begin
    base_sh = W'((mv4 == MOVE_NEG) ? lo4 : b4) << F;
    case (mv4)
      MOVE_DOWN: acc_c = base_sh - p4 + HALF_W;
      default:   acc_c = base_sh + p4 + HALF_W;
    endcase
    r_raw = acc_c[W-1:F];
    if (r_raw < {1'b0, lo4}) r_c = lo4;
    else if (r_raw > {1'b0, hi4}) r_c = hi4;
    else r_c = r_raw[V-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rsp.shaped_value <= r_c;
    end
  end

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      rsp.valid <= 1'b0;
    end else if (adv) begin
      vld       <= {vld[3:1], req.valid};
      rsp.valid <= vld[4];
    end
  end

  // ---------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------
  a_range_ordered: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> (lo1 <= hi1 && b1 >= lo1 && b1 <= hi1))
    else $error("stage 1 range or base out of order");

  a_gain_unit: assert property (@(posedge clk) disable iff (rst)
    vld[3] |-> (m3 <= ONE))
    else $error("stage 3 gain above one");

  a_result_in_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (r_raw >= {1'b0, lo4} && r_raw <= {1'b0, hi4}))
    else $error("unclamped result left the range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!rsp.valid && vld == '0))
    else $error("pipeline not empty after reset");

endmodule

// ===== test/tb_modulation_range_shaper.sv =====
// tb_modulation_range_shaper: self-checking bench for the modulation range shaper.
// Depends on mrs_pkg, mrs_req_if, mrs_rsp_if and modulation_range_shaper from src.
`timescale 1ns / 1ps

import mrs_pkg::*;

// polarity code three has no name in the package; the block treats it as negative
localparam logic [1:0] POL_NEG_ALT = 2'd3;

typedef struct packed {
  logic [15:0] base_value;
  logic [15:0] range_min;
  logic [15:0] range_max;
  logic [16:0] source_level;
  logic [16:0] depth;
  logic [1:0]  polarity;
} shaper_req_t;

// Holds the shaped values still owed by the block, oldest first.
class shaped_value_board;
  localparam int FRAC = 16;
  localparam longint unsigned UNITY = 64'd1 << FRAC;
  localparam longint unsigned HALF_LSB = 64'd1 << (FRAC - 1);

  logic [15:0] owed_q[$];
  int          mismatches;
  int          checked;
  int          pol_seen[4];

  function automatic logic [15:0] shape(shaper_req_t r);
    longint unsigned b, lo, hi, s, d, term, k, g, acc;
    move_t how;
    lo = r.range_min;
    hi = r.range_max;
    if (hi < lo) begin
      lo = r.range_max;
      hi = r.range_min;
    end
    b = r.base_value;
    if (b < lo) b = lo;
    else if (b > hi) b = hi;
    s = (r.source_level > UNITY) ? UNITY : r.source_level;
    d = (r.depth > UNITY) ? UNITY : r.depth;
    case (r.polarity)
      POL_POS: begin
        how = MOVE_UP;
        term = s;
      end
      POL_BIP: begin
        if (2 * s >= UNITY) begin
          how = MOVE_UP;
          term = 2 * s - UNITY;
        end else begin
          how = MOVE_DOWN;
          term = UNITY - 2 * s;
        end
      end
      default: begin
        how = MOVE_NEG;
        term = s;
      end
    endcase
    k = (d * term + HALF_LSB) >> FRAC;
    case (how)
      MOVE_UP:   acc = b * UNITY + k * (hi - b) + HALF_LSB;
      MOVE_DOWN: acc = b * UNITY - k * (b - lo) + HALF_LSB;
      default: begin
        g = UNITY - d + k;
        acc = lo * UNITY + (b - lo) * g + HALF_LSB;
      end
    endcase
    acc = acc >> FRAC;
    if (acc < lo) acc = lo;
    else if (acc > hi) acc = hi;
    return acc[15:0];
  endfunction

  function void note_request(shaper_req_t r);
    owed_q.push_back(shape(r));
    pol_seen[r.polarity]++;
  endfunction

  function void check_result(logic [15:0] got);
    logic [15:0] want;
    checked++;
    if (owed_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected shaped_value %0d with nothing owed", got);
      return;
    end
    want = owed_q.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("shaped_value mismatch #%0d: expected %0d got %0d",
                 checked, want, got);
    end
  endfunction

  function int pending();
    return owed_q.size();
  endfunction
endclass

module tb_modulation_range_shaper;
  // Generous bound: ~930 words, each at worst a sender gap plus a receiver
  // that may only take one word in sixteen cycles, then some slack.
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_WORDS = 900;

  logic clk;
  logic rst;
  int   cycle_count;
  int   directed_count;

  shaped_value_board board;

  mrs_req_if #(.VALUE_BITS(16), .FRACTION_BITS(16)) req_bus ();
  mrs_rsp_if #(.VALUE_BITS(16)) rsp_bus ();

  modulation_range_shaper dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Both handshakes are sampled at the edge, before any NBA from this
  // bench lands, so acceptance is judged on the values the block saw.
  always @(posedge clk) begin
    if (!rst) begin
      if (req_bus.valid && req_bus.ready)
        board.note_request({req_bus.base_value, req_bus.range_min, req_bus.range_max,
                            req_bus.source_level, req_bus.depth, req_bus.polarity});
      if (rsp_bus.valid && rsp_bus.ready)
        board.check_result(rsp_bus.shaped_value);
    end
  end

  // Receiver back-pressure: for each stretch of random length pick either a free
  // stretch (always ready) or a 16-bit stall mask that repeats. A mask
  // is never all zero, so the pipe always drains eventually.
  int          stall_left;
  int          stall_phase;
  logic [15:0] stall_mask;
  bit          stall_free;

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(50, 300);
      stall_free = ($urandom_range(0, 3) == 0);
      stall_mask = 16'($urandom);
      if (stall_mask == '0) stall_mask = 16'h0001;
    end
    stall_left--;
    stall_phase = (stall_phase + 1) % 16;
    rsp_bus.ready <= stall_free || stall_mask[stall_phase];
  end

  function automatic shaper_req_t make_req(int b, int lo, int hi, int s, int d,
                                           logic [1:0] pol);
    shaper_req_t r;
    r.base_value   = b[15:0];
    r.range_min    = lo[15:0];
    r.range_max    = hi[15:0];
    r.source_level = s[16:0];
    r.depth        = d[16:0];
    r.polarity     = pol;
    return r;
  endfunction

  // Q1.16 level: a quarter full 17-bit (about half saturating), an eighth exact
  // corners at zero and around one half and one, the rest inside 0..1.0.
  function automatic logic [16:0] random_q116();
    logic [16:0] corners [8];
    corners = '{17'd0, 17'd1, 17'd32767, 17'd32768, 17'd32769,
                17'd65535, 17'd65536, 17'd65537};
    case ($urandom_range(0, 7))
      0, 1:    return 17'($urandom_range(0, 131071));
      2:       return corners[$urandom_range(0, 7)];
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic shaper_req_t random_req();
    shaper_req_t r;
    int sel, lo, hi, span, b;
    sel = $urandom_range(0, 9);
    if (sel < 4) begin
      // fully random; about half of these come with a reversed range
      b  = $urandom_range(0, 65535);
      lo = $urandom_range(0, 65535);
      hi = $urandom_range(0, 65535);
    end else if (sel < 8) begin
      // narrow range, base near or just outside it
      lo   = $urandom_range(0, 65535);
      span = $urandom_range(0, 512);
      hi   = (lo + span > 65535) ? 65535 : lo + span;
      b    = lo - 16 + $urandom_range(0, span + 32);
      if (b < 0) b = 0;
      if (b > 65535) b = 65535;
      if ($urandom_range(0, 1)) begin
        span = lo;
        lo = hi;
        hi = span;
      end
    end else if (sel == 8) begin
      lo = $urandom_range(0, 65535);
      hi = lo;
      b  = $urandom_range(0, 65535);
    end else begin
      lo = 0;
      hi = 65535;
      b  = $urandom_range(0, 65535);
    end
    r = make_req(b, lo, hi, 0, 0, 2'($urandom_range(0, 3)));
    r.source_level = random_q116();
    r.depth        = random_q116();
    return r;
  endfunction

  // Raises valid with the word and holds it until taken. Returns in the
  // step of the accepting edge with no NBA yet made to valid in that step.
  task automatic send_word(input shaper_req_t r);
    req_bus.valid        <= 1'b1;
    req_bus.base_value   <= r.base_value;
    req_bus.range_min    <= r.range_min;
    req_bus.range_max    <= r.range_max;
    req_bus.source_level <= r.source_level;
    req_bus.depth        <= r.depth;
    req_bus.polarity     <= r.polarity;
    do @(posedge clk); while (!req_bus.ready);
  endtask

  task automatic idle(input int cycles);
    req_bus.valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until the block owes nothing; always lets at least one edge pass.
  task automatic wait_drained();
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    shaper_req_t directed_q[$];
    int sent;
    int burst;

    board = new();
    rst = 1'b1;
    req_bus.valid        = 1'b0;
    req_bus.base_value   = '0;
    req_bus.range_min    = '0;
    req_bus.range_max    = '0;
    req_bus.source_level = '0;
    req_bus.depth        = '0;
    req_bus.polarity     = POL_NEG;

    // field extremes, each polarity, and the named corner cases
    directed_q = '{
      make_req(0, 0, 0, 0, 0, POL_NEG),
      make_req(65535, 65535, 65535, 131071, 131071, POL_NEG_ALT),
      make_req(4096, 0, 65535, 65536, 65536, POL_POS),       // full push to max
      make_req(4096, 0, 65535, 32768, 65536, POL_POS),
      make_req(100, 0, 65535, 65537, 131071, POL_POS),       // both saturate
      make_req(30000, 1000, 60000, 32768, 65536, POL_BIP),   // bipolar center
      make_req(30000, 1000, 60000, 0, 65536, POL_BIP),       // full pull to min
      make_req(30000, 1000, 60000, 65536, 65536, POL_BIP),
      make_req(30000, 1000, 60000, 32767, 40000, POL_BIP),   // just below center
      make_req(30000, 1000, 60000, 0, 65536, POL_NEG),
      make_req(30000, 1000, 60000, 12345, 0, POL_NEG),       // zero depth
      make_req(30000, 1000, 60000, 65536, 65536, POL_NEG),
      make_req(30000, 50000, 100, 20000, 50000, POL_POS),    // reversed range
      make_req(5, 1000, 2000, 10000, 60000, POL_BIP),        // base under range
      make_req(60000, 1000, 2000, 10000, 60000, POL_NEG),    // base over range
      make_req(0, 12345, 12345, 65536, 65536, POL_POS),      // single-value range
      make_req(65535, 12345, 12345, 0, 65536, POL_BIP),
      make_req(40000, 2000, 50000, 30000, 30000, POL_NEG_ALT),
      make_req(1, 0, 2, 65536, 32768, POL_POS),              // rounds half up
      make_req(20000, 0, 65535, 0, 131071, POL_NEG),
      make_req(16'hAAAA, 16'h5555, 16'hFFFF, 17'h0AAAA, 17'h15555, POL_POS),
      make_req(16'h5555, 16'hAAAA, 16'h5554, 17'h15555, 17'h0AAAA, POL_BIP)
    };
    directed_count = directed_q.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed part: back to back, then a gap now and then
    foreach (directed_q[i]) begin
      send_word(directed_q[i]);
      if (i % 7 == 6) idle($urandom_range(1, 4));
    end
    wait_drained();

    // random part: bursts of random length separated by random gaps,
    // with one full drain in the middle
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      repeat (burst) begin
        send_word(random_req());
        sent++;
      end
      if (sent >= RANDOM_WORDS / 2 && sent - burst < RANDOM_WORDS / 2)
        wait_drained();
      else if (sent < RANDOM_WORDS)
        idle($urandom_range(1, 8));
    end

    // drain, then keep clocking to catch strays from the five-stage pipe
    req_bus.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (10) @(posedge clk);

    $display("Covered %0d words (%0d directed, %0d random) under bursty send and stalls.",
             board.checked, directed_count, sent);
    $display("Polarity mix neg/pos/bip/alt = %0d/%0d/%0d/%0d, mismatches = %0d.",
             board.pol_seen[0], board.pol_seen[1], board.pol_seen[2], board.pol_seen[3],
             board.mismatches);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
